### hdl/mlfq_pkg.sv
// Shared types, codes and constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

  // Queue levels and field widths
  localparam int LEVELS     = 3;
  localparam int LVL_W      = 2;
  localparam int BEST_W     = $clog2(LEVELS + 1);
  localparam int SLICE_W    = 8;
  localparam int HOLD_W     = 4;
  localparam int TICK_W     = 16;
  localparam int FUNC_W     = 3;
  localparam int SLOT_IN_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

  // Register reset values
  localparam logic [SLICE_W-1:0] SLICE0_RST = 8'd2;
  localparam logic [SLICE_W-1:0] SLICE1_RST = 8'd4;
  localparam logic [SLICE_W-1:0] SLICE2_RST = 8'd8;
  localparam logic [TICK_W-1:0]  BOOST_RST  = 16'd1000;

  // Command codes
  typedef enum logic [FUNC_W-1:0] {
    FN_TICK    = 3'd0,
    FN_YIELD   = 3'd1,
    FN_SET     = 3'd2,
    FN_HOLD    = 3'd3,
    FN_RELEASE = 3'd4
  } func_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLICE0 = 2'd0,
    CFG_SLICE1 = 2'd1,
    CFG_SLICE2 = 2'd2,
    CFG_BOOST  = 2'd3
  } cfg_reg_t;

  // Write request into the task table
  typedef struct packed {
    logic               lvl_we;
    logic               slc_we;
    logic               hld_we;
    logic               flag_we;
    logic               if_present;
    logic [LVL_W-1:0]   level;
    logic [SLICE_W-1:0] slice;
    logic [HOLD_W-1:0]  hold;
    logic               present;
    logic               ready;
  } tbl_wr_t;

  // Registered read result of the task table
  typedef struct packed {
    logic [LVL_W-1:0]   level;
    logic [SLICE_W-1:0] slice;
    logic [HOLD_W-1:0]  hold;
    logic               present;
    logic               ready;
  } tbl_rd_t;

  // Slice length for a level; every level past 1 uses the last register
  function automatic logic [SLICE_W-1:0] slice_for(
    input logic [LVL_W-1:0]   lvl,
    input logic [SLICE_W-1:0] s0,
    input logic [SLICE_W-1:0] s1,
    input logic [SLICE_W-1:0] s2
  );
    logic [SLICE_W-1:0] res;
    case (lvl)
      2'd0:    res = s0;
      2'd1:    res = s1;
      default: res = s2;
    endcase
    return res;
  endfunction

endpackage

### hdl/mlfq_cmd_if.sv
// Command channel: valid/ready handshake with one scheduler command per transaction.
interface mlfq_cmd_if import mlfq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [SLOT_IN_W-1:0] slot_index;
  logic                 slot_present;
  logic                 slot_ready;

  modport source (
    output valid, func, slot_index, slot_present, slot_ready,
    input  ready
  );
  modport sink (
    input  valid, func, slot_index, slot_present, slot_ready,
    output ready
  );
endinterface

### hdl/mlfq_res_if.sv
// Result channel: valid/ready handshake carrying the running task after each command.
interface mlfq_res_if import mlfq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SLOT_IN_W-1:0] running_slot;
  logic                 switched;
  logic [LVL_W-1:0]     running_level;

  modport source (
    output valid, running_slot, switched, running_level,
    input  ready
  );
  modport sink (
    input  valid, running_slot, switched, running_level,
    output ready
  );
endinterface

### hdl/mlfq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/mlfq_store.sv
// Task table: present/ready flags, entry valid bits and the level, slice and hold RAMs.
module mlfq_store import mlfq_pkg::*; #(
  parameter int TASK_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [$clog2(TASK_SLOTS)-1:0] wr_addr,
  input  tbl_wr_t                       wr,
  input  logic [$clog2(TASK_SLOTS)-1:0] rd_addr,
  output tbl_rd_t                       rd
);

  logic [TASK_SLOTS-1:0] present;
  logic [TASK_SLOTS-1:0] ready;
  logic [TASK_SLOTS-1:0] lvl_vld;
  logic [TASK_SLOTS-1:0] slc_vld;
  logic [TASK_SLOTS-1:0] hld_vld;

  logic               lvl_we;
  logic               slc_we;
  logic               new_task;
  logic               lvl_vld_q;
  logic               slc_vld_q;
  logic               hld_vld_q;
  logic               pres_q;
  logic               rdy_q;
  logic [LVL_W-1:0]   lvl_q;
  logic [SLICE_W-1:0] slc_q;
  logic [HOLD_W-1:0]  hld_q;

  // Gate boost writes by the present flag of the entry
  assign lvl_we   = wr.lvl_we && (!wr.if_present || present[wr_addr]);
  assign slc_we   = wr.slc_we && (!wr.if_present || present[wr_addr]);
  assign new_task = wr.flag_we && wr.present && !present[wr_addr];

  // Flags and valid bits; a new task drops its entries back to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= {{(TASK_SLOTS-1){1'b0}}, 1'b1};
      ready   <= {{(TASK_SLOTS-1){1'b0}}, 1'b1};
      lvl_vld <= '0;
      slc_vld <= '0;
      hld_vld <= '0;
    end else begin
      if (wr.flag_we) begin
        present[wr_addr] <= wr.present;
        ready[wr_addr]   <= wr.ready;
      end
      if (new_task) begin
        lvl_vld[wr_addr] <= 1'b0;
        slc_vld[wr_addr] <= 1'b0;
        hld_vld[wr_addr] <= 1'b0;
      end
      if (lvl_we) begin
        lvl_vld[wr_addr] <= 1'b1;
      end
      if (slc_we) begin
        slc_vld[wr_addr] <= 1'b1;
      end
      if (wr.hld_we) begin
        hld_vld[wr_addr] <= 1'b1;
      end
    end
  end

  // Sample flags alongside the RAM read
  always_ff @(posedge clk) begin
    lvl_vld_q <= lvl_vld[rd_addr];
    slc_vld_q <= slc_vld[rd_addr];
    hld_vld_q <= hld_vld[rd_addr];
    pres_q    <= present[rd_addr];
    rdy_q     <= ready[rd_addr];
  end

  mlfq_ram #(.WIDTH(LVL_W), .DEPTH(TASK_SLOTS)) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (wr_addr),
    .wdata (wr.level),
    .raddr (rd_addr),
    .rdata (lvl_q)
  );

  mlfq_ram #(.WIDTH(SLICE_W), .DEPTH(TASK_SLOTS)) u_slc_ram (
    .clk   (clk),
    .we    (slc_we),
    .waddr (wr_addr),
    .wdata (wr.slice),
    .raddr (rd_addr),
    .rdata (slc_q)
  );

  mlfq_ram #(.WIDTH(HOLD_W), .DEPTH(TASK_SLOTS)) u_hld_ram (
    .clk   (clk),
    .we    (wr.hld_we),
    .waddr (wr_addr),
    .wdata (wr.hold),
    .raddr (rd_addr),
    .rdata (hld_q)
  );

  // Unwritten entries read as zero
  assign rd.level   = lvl_vld_q ? lvl_q : '0;
  assign rd.slice   = slc_vld_q ? slc_q : '0;
  assign rd.hold    = hld_vld_q ? hld_q : '0;
  assign rd.present = pres_q;
  assign rd.ready   = rdy_q;

endmodule

### hdl/mlfq_scan.sv
// Shared compare unit: keeps the first runnable slot at the lowest level seen in a scan.
module mlfq_scan import mlfq_pkg::*; #(
  parameter int TASK_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          init,
  input  logic [$clog2(TASK_SLOTS)-1:0] init_slot,
  input  logic                          step,
  input  logic                          cand,
  input  logic [$clog2(TASK_SLOTS)-1:0] slot,
  input  logic [LVL_W-1:0]              level,
  output logic [$clog2(TASK_SLOTS)-1:0] best_slot,
  output logic [BEST_W-1:0]             best_level
);

  // Start from the fallback slot, take a strictly better candidate
  always_ff @(posedge clk) begin
    if (init) begin
      best_slot  <= init_slot;
      best_level <= BEST_W'(LEVELS);
    end else if (step && cand && (BEST_W'(level) < best_level)) begin
      best_slot  <= slot;
      best_level <= BEST_W'(level);
    end
  end

endmodule

### hdl/mlfq_task_scheduler_top.sv
// Top level of the multilevel feedback queue scheduler: sequencer, registers, result stage.
//
// Usage: commands arrive on cmd (tick, yield, set slot, preempt hold, preempt
// release) with a valid/ready handshake; each accepted transaction gives one
// result on res: the running slot, whether it changed, and its queue level.
// The user writes registers via cfg_wr_en/cfg_index/cfg_data only while idle (not enforced).
// One command is processed at a time; cmd.ready is high only in the idle state.
// A yield scans every slot for the next task. A tick that is not held adds a
// scan of every slot, and a boost adds a sweep of every slot before it. Both
// sweeps step one slot per cycle; the scan goes through the single read port
// of the task table and the one compare unit, the boost through its write port.
// Reset: flags show only slot 0 present and ready, all levels, slices and hold
// depths read zero, slot 0 runs, registers take their reset values.
// Stall: the result waits in an output register; the next command is still
// accepted, and its result is held back until the waiting one is taken.
module mlfq_task_scheduler_top import mlfq_pkg::*; #(
  parameter int TASK_SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  mlfq_cmd_if.sink              cmd,
  mlfq_res_if.source            res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_DECODE    = 13'b0000000000010,
    S_BOOST     = 13'b0000000000100,
    S_CUR_RD    = 13'b0000000001000,
    S_CUR_EV    = 13'b0000000010000,
    S_SCAN      = 13'b0000000100000,
    S_SCAN_END  = 13'b0000001000000,
    S_PICK      = 13'b0000010000000,
    S_PICK_FILL = 13'b0000100000000,
    S_HOLD_RD   = 13'b0001000000000,
    S_HOLD_WR   = 13'b0010000000000,
    S_REPORT_RD = 13'b0100000000000,
    S_REPORT    = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  // Control registers
  logic [SLOT_W-1:0]    cur;
  logic [TICK_W-1:0]    tick_count;
  logic [SLICE_W-1:0]   slice_level0;
  logic [SLICE_W-1:0]   slice_level1;
  logic [SLICE_W-1:0]   slice_level2;
  logic [TICK_W-1:0]    boost_period;
  logic                 out_valid;
  logic                 scan_pend;

  // Payload registers
  logic [FUNC_W-1:0]    lat_func;
  logic [SLOT_IN_W-1:0] lat_idx;
  logic                 lat_pres;
  logic                 lat_rdy;
  logic [SLOT_W-1:0]    prior_slot;
  logic                 pick_if_better;
  logic [LVL_W-1:0]     cur_lvl;
  logic [SLOT_W-1:0]    scan_addr;
  logic [SLOT_W-1:0]    scan_cnt;
  logic [SLOT_W-1:0]    scan_slot_q;
  logic [SLOT_IN_W-1:0] out_slot;
  logic                 out_switched;
  logic [LVL_W-1:0]     out_level;

  // Datapath signals
  tbl_wr_t              wr;
  tbl_rd_t              rd;
  logic [SLOT_W-1:0]    wr_addr;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 scan_init;
  logic [SLOT_W-1:0]    best_slot;
  logic [BEST_W-1:0]    best_level;
  logic [TICK_W-1:0]    tick_inc;
  logic                 boost_hit;
  logic                 set_ok;
  logic [SLOT_W-1:0]    set_slot;
  logic [LVL_W-1:0]     demoted;
  logic                 report_go;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

  assign tick_inc  = tick_count + TICK_W'(1);
  assign boost_hit = (tick_inc >= boost_period);
  assign set_ok    = (int'(lat_idx) < TASK_SLOTS);
  assign set_slot  = SLOT_W'(lat_idx);
  assign demoted   = (rd.level < LVL_W'(LEVELS - 1)) ? rd.level + LVL_W'(1) : rd.level;
  assign report_go = !out_valid || res.ready;

  assign cmd.ready         = (state == S_IDLE);
  assign res.valid         = out_valid;
  assign res.running_slot  = out_slot;
  assign res.switched      = out_switched;
  assign res.running_level = out_level;

  // Sequencer: next state, table accesses and scan start
  always_comb begin
    state_next = state;
    wr         = '0;
    wr_addr    = cur;
    rd_addr    = cur;
    scan_init  = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (lat_func)
          FN_TICK: begin
            state_next = boost_hit ? S_BOOST : S_CUR_RD;
          end
          FN_YIELD: begin
            wr.slc_we  = 1'b1;
            wr.slice   = '0;
            scan_init  = 1'b1;
            state_next = S_SCAN;
          end
          FN_SET: begin
            if (set_ok) begin
              wr.flag_we = 1'b1;
              wr.present = lat_pres;
              wr.ready   = lat_rdy;
              wr_addr    = set_slot;
            end
            state_next = S_REPORT_RD;
          end
          FN_HOLD, FN_RELEASE: begin
            state_next = S_HOLD_RD;
          end
          default: begin
            state_next = S_REPORT_RD;
          end
        endcase
      end
      S_BOOST: begin
        wr_addr       = scan_addr;
        wr.lvl_we     = 1'b1;
        wr.level      = '0;
        wr.slc_we     = 1'b1;
        wr.slice      = slice_level0;
        wr.if_present = 1'b1;
        if (scan_addr == LAST_SLOT) begin
          state_next = S_CUR_RD;
        end
      end
      S_CUR_RD: begin
        state_next = S_CUR_EV;
      end
      S_CUR_EV: begin
        wr.slc_we = 1'b1;
        if (rd.slice <= SLICE_W'(1)) begin
          wr.lvl_we = 1'b1;
          wr.level  = demoted;
          wr.slice  = slice_for(demoted, slice_level0, slice_level1, slice_level2);
        end else begin
          wr.slice  = rd.slice - SLICE_W'(1);
        end
        if (rd.hold == '0) begin
          scan_init  = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_REPORT_RD;
        end
      end
      S_SCAN: begin
        rd_addr = scan_addr;
        if (scan_cnt == LAST_SLOT) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        rd_addr = best_slot;
        if (pick_if_better && !(best_level < BEST_W'(cur_lvl))) begin
          state_next = S_REPORT_RD;
        end else begin
          state_next = S_PICK_FILL;
        end
      end
      S_PICK_FILL: begin
        wr_addr = best_slot;
        if (rd.slice == '0) begin
          wr.slc_we = 1'b1;
          wr.slice  = slice_for(rd.level, slice_level0, slice_level1, slice_level2);
        end
        state_next = S_REPORT_RD;
      end
      S_HOLD_RD: begin
        state_next = S_HOLD_WR;
      end
      S_HOLD_WR: begin
        if (lat_func == FN_HOLD) begin
          if (rd.hold != HOLD_MAX) begin
            wr.hld_we = 1'b1;
            wr.hold   = rd.hold + HOLD_W'(1);
          end
        end else if (rd.hold != '0) begin
          wr.hld_we = 1'b1;
          wr.hold   = rd.hold - HOLD_W'(1);
        end
        state_next = S_REPORT_RD;
      end
      S_REPORT_RD: begin
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (report_go) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state, registers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur          <= '0;
      tick_count   <= '0;
      slice_level0 <= SLICE0_RST;
      slice_level1 <= SLICE1_RST;
      slice_level2 <= SLICE2_RST;
      boost_period <= BOOST_RST;
      out_valid    <= 1'b0;
      scan_pend    <= 1'b0;
    end else begin
      state     <= state_next;
      scan_pend <= (state == S_SCAN);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SLICE0: slice_level0 <= cfg_data[SLICE_W-1:0];
          CFG_SLICE1: slice_level1 <= cfg_data[SLICE_W-1:0];
          CFG_SLICE2: slice_level2 <= cfg_data[SLICE_W-1:0];
          CFG_BOOST:  boost_period <= cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (state == S_DECODE && lat_func == FN_TICK) begin
        tick_count <= boost_hit ? '0 : tick_inc;
      end
      if (state == S_PICK_FILL) begin
        cur <= best_slot;
      end
      if (state == S_REPORT && report_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the command, walk the scan and boost index, load the result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.valid) begin
      lat_func   <= cmd.func;
      lat_idx    <= cmd.slot_index;
      lat_pres   <= cmd.slot_present;
      lat_rdy    <= cmd.slot_ready;
      prior_slot <= cur;
    end
    if (state == S_DECODE) begin
      pick_if_better <= 1'b0;
    end
    if (state == S_CUR_EV) begin
      pick_if_better <= (rd.slice > SLICE_W'(1));
      cur_lvl        <= rd.level;
    end
    if (scan_init) begin
      scan_addr <= next_slot(cur);
      scan_cnt  <= '0;
    end else if (state == S_DECODE) begin
      scan_addr <= '0;
    end else if (state == S_BOOST || state == S_SCAN) begin
      scan_addr <= next_slot(scan_addr);
      scan_cnt  <= scan_cnt + SLOT_W'(1);
    end
    scan_slot_q <= scan_addr;
    if (state == S_REPORT && report_go) begin
      out_slot     <= SLOT_IN_W'(cur);
      out_switched <= (cur != prior_slot);
      out_level    <= rd.level;
    end
  end

  mlfq_store #(.TASK_SLOTS(TASK_SLOTS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  mlfq_scan #(.TASK_SLOTS(TASK_SLOTS)) u_scan (
    .clk        (clk),
    .init       (scan_init),
    .init_slot  (cur),
    .step       (scan_pend),
    .cand       (rd.present && rd.ready),
    .slot       (scan_slot_q),
    .level      (rd.level),
    .best_slot  (best_slot),
    .best_level (best_level)
  );

endmodule

### hdl/mlfq_checker.sv
// Port-level checks of the scheduler and the bind that attaches them to the top level.
module mlfq_checker import mlfq_pkg::*; #(
  parameter int TASK_SLOTS = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic [SLOT_IN_W-1:0] running_slot,
  input logic                 switched,
  input logic [LVL_W-1:0]     running_level
);

  // Come out of reset idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!res_valid && cmd_ready))
    else $error("scheduler not idle after reset");

  // Take one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command accepted while busy");

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(running_slot) && $stable(switched) && $stable(running_level)))
    else $error("stalled result changed");

  // Report only real slots and levels
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((int'(running_level) < LEVELS) && (int'(running_slot) < TASK_SLOTS)))
    else $error("result slot or level out of range");

endmodule

bind mlfq_task_scheduler_top mlfq_checker #(.TASK_SLOTS(TASK_SLOTS)) u_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .running_slot  (res.running_slot),
  .switched      (res.switched),
  .running_level (res.running_level)
);
